// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication on clk, disabled in reset
`define SFS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfs assertion failed");
// next-cycle implication on clk, disabled in reset
`define SFS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfs assertion failed");
`else
`define SFS_ASSERT_IMP(lbl, ante, cons)
`define SFS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- sv/sfs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_pkg
// Types and codes of the sprite frame sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

  typedef struct packed {
    logic [15:0] delay;
    logic [11:0] count;
    logic [11:0] start;
    logic [7:0]  dir;
    logic [7:0]  st;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // configuration register indexes
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_WANT_ST = 3'd1;
  localparam logic [2:0] REG_WANT_DR = 3'd2;
  localparam logic [2:0] REG_COLS    = 3'd3;
  localparam logic [2:0] REG_TILE_W  = 3'd4;
  localparam logic [2:0] REG_TILE_H  = 3'd5;
  localparam logic [2:0] REG_IN_USE  = 3'd6;

  // animation modes
  localparam logic [1:0] MODE_STATIC = 2'd0;
  localparam logic [1:0] MODE_SEQ    = 2'd1;
  localparam logic [1:0] MODE_RANDOM = 2'd2;
  localparam logic [1:0] MODE_LOOP   = 2'd3;

  // operations
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_STEP  = 1'b1;

endpackage

// ----- sv/sprite_frame_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Animation entry table with circular flag search and tile sheet lookup.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : requests. in_tuser is the operation (0 write entry, 1 step).
//           A write stores one entry in the table RAM; a step finds the
//           entry matching the configured flags and updates the tile per mode.
//   out_* : one result per request. out_tuser is the error status.
//   cfg_* : register writes, always ready. The user writes them only while
//           the block is idle; the block itself does not enforce this.
// A write goes straight to the output state. A step reduces the pointer,
//   compares one entry at a time on the single RAM read port, then splits
//   the tile on the bit-serial divider; random mode uses the divider first.
// One request is in flight at a time; in_tready is high while idle.
// Reset clears the registers, search pointer, current tile and end flag;
//   table entries are undefined until written.
// A stalled result holds in the output register; the block waits there.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] entry_slot, [11:4] entry_state, [19:12] entry_direction,
  // [31:20] entry_start, [43:32] entry_count, [59:44] entry_delay,
  // [75:60] random_value, [79:76] zero
  input  logic [79:0] in_tdata,
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  // [12:0] tile_index, [28:13] tile_x, [49:29] tile_y,
  // [65:50] frame_delay, [66] sequence_done, [71:67] zero
  output logic [71:0] out_tdata,
  output logic        out_tuser,  // [0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int NW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MODN = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_CMP  = 4'd3;
  localparam logic [3:0] S_CALC = 4'd4;
  localparam logic [3:0] S_RDIV = 4'd5;
  localparam logic [3:0] S_POS  = 4'd6;
  localparam logic [3:0] S_PDIV = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  // configuration
  logic [1:0] mode_r;
  logic [7:0] want_st_r, want_dr_r, cols_r, tw_r, th_r;
  logic [4:0] in_use_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= sfs_pkg::MODE_STATIC;
      want_st_r <= 8'd0;
      want_dr_r <= 8'd0;
      cols_r    <= 8'd1;
      tw_r      <= 8'd16;
      th_r      <= 8'd16;
      in_use_r  <= 5'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sfs_pkg::REG_MODE:    mode_r    <= cfg_data[1:0];
        sfs_pkg::REG_WANT_ST: want_st_r <= cfg_data;
        sfs_pkg::REG_WANT_DR: want_dr_r <= cfg_data;
        sfs_pkg::REG_COLS:    cols_r    <= cfg_data;
        sfs_pkg::REG_TILE_W:  tw_r      <= cfg_data;
        sfs_pkg::REG_TILE_H:  th_r      <= cfg_data;
        sfs_pkg::REG_IN_USE:  in_use_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // control and state
  logic [3:0]  state_r;
  logic [AW-1:0] sp_r, j_r;
  logic [NW-1:0] n_r, i_r;
  logic [12:0] cur_tile_r;
  logic        ended_r;
  logic        out_valid_r;

  // request and work registers
  logic [15:0] rv_r;
  sfs_pkg::entry_t entry_r;
  logic [12:0] tile_r;
  logic        done_r;

  // result registers
  logic        res_status_r;
  logic [12:0] res_tile_r;
  logic [15:0] res_x_r;
  logic [20:0] res_y_r;
  logic [15:0] res_delay_r;
  logic        res_done_r;
  logic [71:0] out_data_r;
  logic        out_user_r;

  // divider
  logic [12:0] dv_rem_r;
  logic [15:0] dv_quo_r, dv_num_r;
  logic [11:0] dv_den_r;
  logic [4:0]  dv_cnt_r;
  logic [12:0] dv_sh;
  logic        dv_ge;

  assign dv_sh = {dv_rem_r[11:0], dv_num_r[15]};
  assign dv_ge = dv_sh >= {1'b0, dv_den_r};

  // RAM
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  sfs_pkg::entry_t ram_wdata, ram_rdata;
  logic [sfs_pkg::ENTRY_W-1:0] ram_rd_raw;

  assign ram_wdata.st    = in_tdata[11:4];
  assign ram_wdata.dir   = in_tdata[19:12];
  assign ram_wdata.start = in_tdata[31:20];
  assign ram_wdata.count = in_tdata[43:32];
  assign ram_wdata.delay = in_tdata[59:44];
  assign ram_waddr = AW'(in_tdata[3:0]);
  assign ram_we = (state_r == S_IDLE) && in_tvalid && (in_tuser == sfs_pkg::OP_WRITE)
                  && (int'(in_tdata[3:0]) < TABLE_ENTRIES);
  assign ram_rdata = sfs_pkg::entry_t'(ram_rd_raw);

  sfs_ram #(
    .WIDTH(sfs_pkg::ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(j_r),
    .rdata(ram_rd_raw)
  );

  // step arithmetic
  logic [11:0] cnt_w;
  logic [12:0] end_w, pulled_w, inc_w, wrap_w;
  logic        hit_w;

  assign cnt_w    = (entry_r.count == 12'd0) ? 12'd1 : entry_r.count;
  assign end_w    = {1'b0, entry_r.start} + {1'b0, cnt_w} - 13'd1;
  assign pulled_w = (cur_tile_r < {1'b0, entry_r.start} || cur_tile_r > end_w)
                    ? {1'b0, entry_r.start} : cur_tile_r;
  assign inc_w    = pulled_w + 13'd1;
  assign wrap_w   = (inc_w > end_w) ? {1'b0, entry_r.start} : inc_w;
  assign hit_w    = (ram_rdata.st == want_st_r) && (ram_rdata.dir == want_dr_r);

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      j_r         <= '0;
      n_r         <= '0;
      i_r         <= '0;
      cur_tile_r  <= 13'd0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
      dv_cnt_r    <= 5'd0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            rv_r         <= in_tdata[75:60];
            res_status_r <= 1'b0;
            res_tile_r   <= 13'd0;
            res_x_r      <= 16'd0;
            res_y_r      <= 21'd0;
            res_delay_r  <= 16'd0;
            res_done_r   <= 1'b0;
            if (in_tuser == sfs_pkg::OP_WRITE) begin
              state_r <= S_OUT;
            end else if (in_use_r == 5'd0) begin
              res_status_r <= 1'b1;
              state_r      <= S_OUT;
            end else begin
              n_r <= (int'(in_use_r) > TABLE_ENTRIES) ? NW'(TABLE_ENTRIES)
                                                      : NW'(in_use_r);
              j_r     <= sp_r;
              i_r     <= '0;
              state_r <= S_MODN;
            end
          end
        end
        S_MODN: begin
          // bring the pointer below the entry count
          if (int'(j_r) >= int'(n_r)) begin
            j_r <= AW'(int'(j_r) - int'(n_r));
          end else begin
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (hit_w) begin
            entry_r <= ram_rdata;
            state_r <= S_CALC;
          end else if (int'(i_r) + 1 == int'(n_r)) begin
            res_status_r <= 1'b1;
            state_r      <= S_OUT;
          end else begin
            i_r     <= i_r + NW'(1);
            j_r     <= (int'(j_r) + 1 == int'(n_r)) ? '0 : j_r + AW'(1);
            state_r <= S_RD;
          end
        end
        S_CALC: begin
          case (mode_r)
            sfs_pkg::MODE_STATIC: begin
              tile_r  <= pulled_w;
              done_r  <= 1'b1;
              state_r <= S_POS;
            end
            sfs_pkg::MODE_SEQ: begin
              tile_r  <= (inc_w > end_w) ? end_w : inc_w;
              done_r  <= (inc_w >= end_w);
              state_r <= S_POS;
            end
            sfs_pkg::MODE_RANDOM: begin
              dv_rem_r <= 13'd0;
              dv_num_r <= rv_r;
              dv_den_r <= cnt_w;
              dv_cnt_r <= 5'd16;
              done_r   <= 1'b0;
              state_r  <= S_RDIV;
            end
            default: begin
              tile_r  <= wrap_w;
              done_r  <= (wrap_w == end_w);
              state_r <= S_POS;
            end
          endcase
        end
        S_RDIV: begin
          if (dv_cnt_r == 5'd0) begin
            tile_r  <= {1'b0, entry_r.start} + dv_rem_r;
            state_r <= S_POS;
          end else begin
            dv_rem_r <= dv_ge ? dv_sh - {1'b0, dv_den_r} : dv_sh;
            dv_num_r <= {dv_num_r[14:0], 1'b0};
            dv_cnt_r <= dv_cnt_r - 5'd1;
          end
        end
        S_POS: begin
          dv_rem_r <= 13'd0;
          dv_quo_r <= 16'd0;
          dv_num_r <= {3'd0, tile_r};
          dv_den_r <= (cols_r == 8'd0) ? 12'd1 : {4'd0, cols_r};
          dv_cnt_r <= 5'd16;
          state_r  <= S_PDIV;
        end
        S_PDIV: begin
          if (dv_cnt_r == 5'd0) begin
            state_r <= S_MUL;
          end else begin
            dv_rem_r <= dv_ge ? dv_sh - {1'b0, dv_den_r} : dv_sh;
            dv_quo_r <= {dv_quo_r[14:0], dv_ge};
            dv_num_r <= {dv_num_r[14:0], 1'b0};
            dv_cnt_r <= dv_cnt_r - 5'd1;
          end
        end
        S_MUL: begin
          res_tile_r  <= tile_r;
          res_x_r     <= {8'd0, tw_r} * {8'd0, dv_rem_r[7:0]};
          res_y_r     <= {13'd0, th_r} * {8'd0, dv_quo_r[12:0]};
          res_delay_r <= entry_r.delay;
          res_done_r  <= done_r;
          sp_r        <= j_r;
          cur_tile_r  <= tile_r;
          ended_r     <= done_r;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
      out_user_r <= res_status_r;
      out_data_r <= {5'd0, res_done_r, res_delay_r, res_y_r, res_x_r, res_tile_r};
    end
  end

`include "assert_macros.svh"

  `SFS_ASSERT_IMP(a_search_idx, state_r == S_CMP, int'(j_r) < int'(n_r))
  `SFS_ASSERT_IMP(a_search_cnt, state_r == S_CMP, int'(i_r) < int'(n_r))
  `SFS_ASSERT_NXT(a_busy_after, in_tvalid && in_tready, state_r != S_IDLE)
  `SFS_ASSERT_IMP(a_err_zero, state_r == S_OUT && res_status_r,
                  res_tile_r == 13'd0 && res_delay_r == 16'd0 && !res_done_r)
  `SFS_ASSERT_IMP(a_ended_hold, state_r == S_MUL && mode_r == sfs_pkg::MODE_STATIC,
                  done_r)
  `SFS_ASSERT_NXT(a_ended_track, state_r == S_MUL, ended_r == res_done_r)

endmodule

// ----- sv/sfs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/tb_sprite_frame_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sprite_frame_sequencer
// Self-checking bench: loads animation tables, steps frames in every mode
// and compares each result against a local model of the sequencer.
// ----------------------------------------------------------------------------
module tb_sprite_frame_sequencer;

  typedef struct packed {
    logic        done;
    logic [15:0] delay;
    logic [20:0] ty;
    logic [15:0] tx;
    logic [12:0] tile;
    logic        err;
  } frame_t;

  class frame_scoreboard;
    frame_t pending[$];
    sfs_pkg::entry_t tbl[16];
    logic [3:0]  ptr;
    logic [12:0] cur_tile;
    logic        ended;
    logic [1:0]  mode;
    logic [7:0]  want_st, want_dr, cols, tw, th;
    logic [4:0]  in_use;
    int errors, checked;

    function void clear();
      ptr = 0; cur_tile = 0; ended = 0; mode = sfs_pkg::MODE_STATIC;
      want_st = 0; want_dr = 0; cols = 1; tw = 16; th = 16; in_use = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] v);
      case (idx)
        sfs_pkg::REG_MODE:    mode = v[1:0];
        sfs_pkg::REG_WANT_ST: want_st = v;
        sfs_pkg::REG_WANT_DR: want_dr = v;
        sfs_pkg::REG_COLS:    cols = v;
        sfs_pkg::REG_TILE_W:  tw = v;
        sfs_pkg::REG_TILE_H:  th = v;
        sfs_pkg::REG_IN_USE:  in_use = v[4:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic op, logic [79:0] d);
      frame_t f;
      int n, j, hit, st, cnt, en, t, c;
      bit found;
      f = '0;
      if (op == sfs_pkg::OP_WRITE) begin
        tbl[d[3:0]] = d[59:4];
      end else begin
        n = (in_use > 16) ? 16 : in_use;
        found = 0; hit = 0;
        for (int i = 0; i < n; i++) begin
          j = (ptr + i) % n;
          if (!found && tbl[j].st == want_st && tbl[j].dir == want_dr) begin
            hit = j; found = 1;
          end
        end
        if (!found) f.err = 1;
        else begin
          ptr = hit;
          st = tbl[hit].start;
          cnt = (tbl[hit].count == 0) ? 1 : tbl[hit].count;
          en = st + cnt - 1;
          t = cur_tile;
          if (t < st || t > en) t = st;
          case (mode)
            sfs_pkg::MODE_STATIC: ended = 1;
            sfs_pkg::MODE_SEQ: begin
              t = (t + 1 > en) ? en : t + 1;
              ended = (t == en);
            end
            sfs_pkg::MODE_RANDOM: begin
              t = st + d[75:60] % cnt;
              ended = 0;
            end
            default: begin
              t = t + 1;
              if (t > en) t = st;
              ended = (t == en);
            end
          endcase
          cur_tile = t[12:0];
          c = (cols == 0) ? 1 : cols;
          f.tile = cur_tile;
          f.tx = tw * (cur_tile % c);
          f.ty = th * (cur_tile / c);
          f.delay = tbl[hit].delay;
          f.done = ended;
        end
      end
      pending.push_back(f);
    endfunction

    task check_frame(logic [71:0] d, logic status);
      frame_t e, g;
      g = {d[66:0], status};
      if (pending.size() == 0) begin
        report_error("result with nothing pending");
        return;
      end
      e = pending.pop_front();
      checked++;
      if (g.err !== e.err) report_error("status");
      if (g.tile !== e.tile) report_error("tile_index");
      if (g.tx !== e.tx) report_error("tile_x");
      if (g.ty !== e.ty) report_error("tile_y");
      if (g.delay !== e.delay) report_error("frame_delay");
      if (g.done !== e.done) report_error("sequence_done");
    endtask

    task report_error(string what);
      errors++;
      if (errors <= 30) $display("mismatch: %s at %0t", what, $realtime);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tuser = 0, out_tready = 0;
  logic [79:0] in_tdata = '0;
  logic in_tready, out_tvalid, out_tuser, cfg_ready;
  logic [71:0] out_tdata;
  logic cfg_valid = 0;
  logic [2:0] cfg_index = 0;
  logic [7:0] cfg_data = 0;
  frame_scoreboard sb;
  int cycles = 0, sent = 0;
  bit hold_off = 0;

  sprite_frame_sequencer uut (.*);

  initial forever #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: own stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_frame(out_tdata, out_tuser);
    if (hold_off) out_tready <= 0;
    else out_tready <= (cycles % 64 < 32) ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  task automatic write_reg(logic [2:0] idx, logic [7:0] v);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    cfg_valid <= 0;
  endtask

  task automatic send(logic op, logic [79:0] d);
    in_tvalid <= 1; in_tuser <= op; in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, d);
    sent++;
  endtask

  task automatic gap();
    in_tvalid <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [79:0] entry_req(int slot, int s, int dr,
      int st, int cnt, int dl, int rv);
    return {4'd0, rv[15:0], dl[15:0], cnt[11:0], st[11:0], dr[7:0], s[7:0], slot[3:0]};
  endfunction

  // step request: random junk in the entry fields, random value on top
  function automatic logic [79:0] step_req(logic [15:0] rv);
    logic [79:0] d;
    d = {16'd0, $urandom(), $urandom()};
    d[75:60] = rv;
    d[79:76] = 4'd0;
    return d;
  endfunction

  // fill all slots; slot 0..15 get flags from small pool so matches are common
  task automatic load_table(bit wide);
    for (int s = 0; s < 16; s++) begin
      send(sfs_pkg::OP_WRITE, entry_req(s, $urandom_range(0, 3), $urandom_range(0, 1),
           wide ? $urandom_range(0, 4095) : $urandom_range(0, 40),
           wide ? $urandom_range(0, 4095) : $urandom_range(0, 8),
           $urandom, $urandom));
      if ($urandom_range(0, 3) == 0) gap();
    end
  endtask

  task automatic random_phase(int items);
    int burst;
    while (items > 0) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && items > 0; k++, items--) begin
        if ($urandom_range(0, 9) == 0)
          send(sfs_pkg::OP_WRITE, entry_req($urandom_range(0, 15), $urandom_range(0, 3),
               $urandom_range(0, 1), $urandom_range(0, 60), $urandom_range(0, 9),
               $urandom, $urandom));
        else send(sfs_pkg::OP_STEP, step_req(16'($urandom)));
      end
      if ($urandom_range(0, 2) != 0) gap();
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // empty table error, then extremes
    send(sfs_pkg::OP_STEP, step_req(16'd0));
    send(sfs_pkg::OP_WRITE, entry_req(0, 255, 255, 4095, 4095, 65535, 65535));
    send(sfs_pkg::OP_WRITE, entry_req(1, 0, 0, 0, 0, 0, 0));
    for (int s = 2; s < 16; s++) send(sfs_pkg::OP_WRITE, entry_req(s, 1, 1, s, s, s, 0));
    drain();
    write_reg(sfs_pkg::REG_IN_USE, 8'd31);
    write_reg(sfs_pkg::REG_COLS, 8'd0);
    for (int m = 0; m < 4; m++) begin
      write_reg(sfs_pkg::REG_MODE, 8'(m));
      send(sfs_pkg::OP_STEP, step_req(16'd65535));
      send(sfs_pkg::OP_STEP, step_req(16'd0));
      drain();
    end
    write_reg(sfs_pkg::REG_WANT_ST, 8'hFF);
    write_reg(sfs_pkg::REG_WANT_DR, 8'hFF);
    write_reg(sfs_pkg::REG_TILE_W, 8'd255);
    write_reg(sfs_pkg::REG_TILE_H, 8'd255);
    write_reg(sfs_pkg::REG_COLS, 8'd1);
    send(sfs_pkg::OP_STEP, step_req(16'd65535));
    send(sfs_pkg::OP_STEP, step_req(16'd12345));
    drain();
    write_reg(sfs_pkg::REG_WANT_ST, 8'h55);
    send(sfs_pkg::OP_STEP, step_req(16'd1));   // no match
    drain();
    // long receiver hold-off while the sender keeps offering
    hold_off = 1;
    fork
      begin repeat (400) @(posedge clk); hold_off = 0; end
      random_phase(5);
    join
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      load_table(ph % 4 == 3);
      drain();
      write_reg(sfs_pkg::REG_MODE, 8'($urandom_range(0, 3)));
      write_reg(sfs_pkg::REG_WANT_ST, 8'($urandom_range(0, 3)));
      write_reg(sfs_pkg::REG_WANT_DR, 8'($urandom_range(0, 1)));
      write_reg(sfs_pkg::REG_COLS, (ph == 0) ? 8'd255 : 8'($urandom_range(0, 255)));
      write_reg(sfs_pkg::REG_TILE_W, (ph == 1) ? 8'd1 : 8'($urandom_range(1, 255)));
      write_reg(sfs_pkg::REG_TILE_H, (ph == 1) ? 8'd1 : 8'($urandom_range(1, 255)));
      write_reg(sfs_pkg::REG_IN_USE, (ph == 2) ? 8'd1 : 8'($urandom_range(0, 20)));
      random_phase(150);
      drain();
    end

    $display("covered %0d requests, %0d results checked, all modes and table sizes",
             sent, sb.checked);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+sv
sv/sfs_pkg.sv
sv/sfs_ram.sv
sv/sprite_frame_sequencer.sv
tb/tb_sprite_frame_sequencer.sv
